// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define TLPT_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlpt assertion failed");

// next-cycle implication, ignored while reset is high
`define TLPT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlpt assertion failed");

`endif

// ----- rtl/tlpt_pkg.sv -----
// types and constants of the two-level page table engine
`default_nettype none

package tlpt_pkg;

   localparam int unsigned PG_SHIFT    = 12;
   localparam int unsigned SLOT_SHIFT  = 22;
   localparam int unsigned SUB_BITS    = 10;
   localparam int unsigned SUB_ENTRIES = 1024;
   localparam int unsigned PG_BITS     = 20;
   localparam int unsigned DUMMY_BITS  = 27;
   localparam int unsigned PHYS_BITS   = 39;
   localparam int unsigned DONE_BITS   = 15;

   localparam logic [DONE_BITS-1:0] DONE_MAX = '1;

   // request op codes
   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNALIGNED = 2'd1;
   localparam logic [1:0] ST_RANGE     = 2'd2;
   localparam logic [1:0] ST_HOLE      = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] io_address;
      logic [38:0] phys_address;
      logic [31:0] length_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [38:0] phys_result;
      logic [14:0] pages_done;
   } rsp_type;

   // request classification handed from the checker to the walker
   typedef struct packed {
      logic       quick;
      logic [1:0] status;
   } chk_type;

endpackage

`default_nettype wire

// ----- rtl/tlpt_check.sv -----
// request checker: alignment and window tests of an incoming request
`default_nettype none

module tlpt_check #(
   parameter int unsigned FIRST_LEVEL_SLOTS = 16
) (
   input  tlpt_pkg::req_type req,
   output tlpt_pkg::chk_type chk
);

   localparam logic [32:0] WINDOW = 33'(FIRST_LEVEL_SLOTS) << tlpt_pkg::SLOT_SHIFT;

   logic [32:0] io_ext;
   logic [32:0] end_addr;
   logic        beyond;
   logic        over;
   logic [11:0] align_low;

   assign io_ext    = {1'b0, req.io_address};
   assign end_addr  = io_ext + {1'b0, req.length_bytes};
   assign beyond    = io_ext >= WINDOW;
   assign over      = beyond || (end_addr > WINDOW);
   assign align_low = req.io_address[11:0] | req.length_bytes[11:0]
                    | ((req.op == tlpt_pkg::OP_MAP) ? req.phys_address[11:0] : 12'd0);

   always_comb begin
      chk.quick  = 1'b0;
      chk.status = tlpt_pkg::ST_OK;
      unique case (req.op) inside
         tlpt_pkg::OP_MAP, tlpt_pkg::OP_UNMAP: begin
            if (align_low != 12'd0) begin
               chk.quick  = 1'b1;
               chk.status = tlpt_pkg::ST_UNALIGNED;
            end else if (over) begin
               chk.quick  = 1'b1;
               chk.status = tlpt_pkg::ST_RANGE;
            end
         end
         tlpt_pkg::OP_XLATE: begin
            if (beyond) begin
               chk.quick  = 1'b1;
               chk.status = tlpt_pkg::ST_RANGE;
            end
         end
         tlpt_pkg::OP_NONE: begin
            chk.quick = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/tlpt_walk.sv -----
// table walker: page entry memory, slot flags and the per-page sequencer
`default_nettype none

module tlpt_walk #(
   parameter int unsigned FIRST_LEVEL_SLOTS = 16,
   parameter int unsigned FRAME_BITS        = 27
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tlpt_pkg::req_type                   req,
   input  tlpt_pkg::chk_type                   chk,
   input  logic [tlpt_pkg::DUMMY_BITS-1:0]     dummy_page_frame,
   input  logic                                out_free,
   output logic                                idle,
   output logic                                fin,
   output tlpt_pkg::rsp_type                   res
);

   localparam int unsigned SLOT_BITS = (FIRST_LEVEL_SLOTS > 1) ? $clog2(FIRST_LEVEL_SLOTS) : 1;
   localparam int unsigned MEM_DEPTH = FIRST_LEVEL_SLOTS * tlpt_pkg::SUB_ENTRIES;
   localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);
   localparam int unsigned PHYS_W    = FRAME_BITS + tlpt_pkg::PG_SHIFT;

   localparam logic [tlpt_pkg::SUB_BITS-1:0] SUB_LAST = '1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WALK = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]                       state_ff, state_in;
   logic [FIRST_LEVEL_SLOTS-1:0]     slot_used_ff, slot_used_in;
   logic [1:0]                       op_ff, op_in;
   logic [tlpt_pkg::PG_BITS-1:0]     pg_ff, pg_in;
   logic [tlpt_pkg::PG_BITS-1:0]     rem_ff, rem_in;
   logic [FRAME_BITS-1:0]            frame_ff, frame_in;
   logic [tlpt_pkg::DONE_BITS-1:0]   done_ff, done_in;
   logic [1:0]                       status_ff, status_in;
   logic [tlpt_pkg::SUB_BITS-1:0]    fill_ff, fill_in;
   logic                             hit_ff, hit_in;
   logic [FRAME_BITS-1:0]            rd_data_ff;
   logic [FRAME_BITS-1:0]            page_mem_ff [MEM_DEPTH];

   logic                             mem_we;
   logic [MEM_AW-1:0]                mem_wa;
   logic [FRAME_BITS-1:0]            mem_wd;
   logic                             mem_re;
   logic [MEM_AW-1:0]                mem_ra;

   logic [FRAME_BITS-1:0]            dummy_frame;
   logic [SLOT_BITS-1:0]             cur_slot;
   logic                             cur_used;
   logic [SLOT_BITS-1:0]             req_slot;
   logic [tlpt_pkg::PG_BITS-1:0]     req_pg;
   logic [tlpt_pkg::PG_BITS-1:0]     req_pages;
   logic [tlpt_pkg::PG_BITS-1:0]     fill_pg;
   logic [FRAME_BITS-1:0]            frame_sel;
   logic [PHYS_W-1:0]                phys_wide;
   logic                             done_sat;

   assign dummy_frame = FRAME_BITS'(dummy_page_frame);
   assign cur_slot    = pg_ff[tlpt_pkg::SUB_BITS +: SLOT_BITS];
   assign cur_used    = slot_used_ff[cur_slot];
   assign req_slot    = req.io_address[tlpt_pkg::SLOT_SHIFT +: SLOT_BITS];
   assign req_pg      = req.io_address[31:tlpt_pkg::PG_SHIFT];
   assign req_pages   = req.length_bytes[31:tlpt_pkg::PG_SHIFT];
   assign fill_pg     = {pg_ff[tlpt_pkg::PG_BITS-1:tlpt_pkg::SUB_BITS], fill_ff};
   assign done_sat    = (done_ff == tlpt_pkg::DONE_MAX);

   // translated frame: the stored entry, or the dummy frame for an unused slot
   assign frame_sel = hit_ff ? rd_data_ff : dummy_frame;
   assign phys_wide = {frame_sel, {tlpt_pkg::PG_SHIFT{1'b0}}};

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      slot_used_in = slot_used_ff;
      op_in        = op_ff;
      pg_in        = pg_ff;
      rem_in       = rem_ff;
      frame_in     = frame_ff;
      done_in      = done_ff;
      status_in    = status_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      mem_we       = 1'b0;
      mem_wa       = pg_ff[MEM_AW-1:0];
      mem_wd       = frame_ff;
      mem_re       = 1'b0;
      mem_ra       = req_pg[MEM_AW-1:0];
      fin          = 1'b0;
      res.status      = status_ff;
      res.phys_result = '0;
      res.pages_done  = done_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req.op;
               pg_in     = req_pg;
               rem_in    = req_pages;
               frame_in  = FRAME_BITS'(req.phys_address[38:tlpt_pkg::PG_SHIFT]);
               done_in   = '0;
               status_in = chk.status;
               fill_in   = '0;
               if (chk.quick) begin
                  state_in = S_FIN;
               end else if (req.op == tlpt_pkg::OP_XLATE) begin
                  hit_in   = slot_used_ff[req_slot];
                  mem_re   = 1'b1;
                  state_in = S_READ;
               end else if (req_pages == '0) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_READ: begin
            fin             = 1'b1;
            res.phys_result = tlpt_pkg::PHYS_BITS'(phys_wide);
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            fin = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (op_ff == tlpt_pkg::OP_MAP && !cur_used) begin
               // first touch of the slot: sweep it with the dummy frame
               fill_in  = '0;
               state_in = S_FILL;
            end else begin
               if (op_ff == tlpt_pkg::OP_MAP) begin
                  mem_we   = 1'b1;
                  mem_wd   = frame_ff;
                  frame_in = frame_ff + FRAME_BITS'(1);
                  if (!done_sat) begin
                     done_in = done_ff + tlpt_pkg::DONE_BITS'(1);
                  end
               end else if (cur_used) begin
                  mem_we = 1'b1;
                  mem_wd = dummy_frame;
                  if (!done_sat) begin
                     done_in = done_ff + tlpt_pkg::DONE_BITS'(1);
                  end
               end else begin
                  status_in = tlpt_pkg::ST_HOLE;
               end
               pg_in  = pg_ff + tlpt_pkg::PG_BITS'(1);
               rem_in = rem_ff - tlpt_pkg::PG_BITS'(1);
               if (rem_ff == tlpt_pkg::PG_BITS'(1)) begin
                  state_in = S_FIN;
               end
            end
         end
         S_FILL: begin
            mem_we  = 1'b1;
            mem_wa  = fill_pg[MEM_AW-1:0];
            mem_wd  = dummy_frame;
            fill_in = fill_ff + tlpt_pkg::SUB_BITS'(1);
            if (fill_ff == SUB_LAST) begin
               slot_used_in[cur_slot] = 1'b1;
               state_in               = S_WALK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slot_used_ff <= '0;
      end else begin
         state_ff     <= state_in;
         slot_used_ff <= slot_used_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pg_ff     <= pg_in;
      rem_ff    <= rem_in;
      frame_ff  <= frame_in;
      done_ff   <= done_in;
      status_ff <= status_in;
      fill_ff   <= fill_in;
      hit_ff    <= hit_in;
   end

   // page entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= page_mem_ff[mem_ra];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/two_level_page_table_engine_unit.sv -----
// top level of the two-level page table engine
`default_nettype none

// Two-level IO page table with 4 KiB pages: address bits 31..22 pick a
// first-level slot (FIRST_LEVEL_SLOTS of them, 4 MiB each) and bits 21..12
// pick one of 1024 page entries. Entries live in one synchronous memory of
// FIRST_LEVEL_SLOTS*1024 frames; per-slot used flags sit in flops cleared by
// reset. The memory itself is never cleared: a slot is swept with the dummy
// frame the first time a map touches it, so no clearing pass follows reset.
// One request is worked at a time. Translate does one memory read with a
// registered result. Map and unmap write one entry per cycle through the
// single memory write port; unmap writes nothing for pages of an unused
// slot, and each slot a map touches for the first time is first found
// unused and then swept over all 1024 entries. Malformed requests and the
// unused op code go straight to the finish state. A finished result waits
// in the output register while the next request is already being worked.
module two_level_page_table_engine_unit #(
   parameter int unsigned FIRST_LEVEL_SLOTS = 16,
   parameter int unsigned FRAME_BITS        = 27
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tlpt_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tlpt_pkg::rsp_type               rsp_data,
   // dummy frame register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tlpt_pkg::DUMMY_BITS-1:0] csr_dummy_page_frame
);

`include "assert_macros.svh"

   logic [tlpt_pkg::DUMMY_BITS-1:0] dummy_ff, dummy_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tlpt_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   tlpt_pkg::chk_type               chk;
   tlpt_pkg::rsp_type               walk_res;
   logic                            walk_idle;
   logic                            walk_fin;
   logic                            req_beat;
   logic                            out_free;
   logic                            res_load;
   logic                            out_counted;
   logic                            out_rejected;
   logic                            out_empty;

   // register writes are always taken; the user must write only while the block is idle, the block does not enforce it
   assign csr_ready = 1'b1;
   assign dummy_in  = (csr_valid) ? csr_dummy_page_frame : dummy_ff;

   // a new request enters only when the walker has nothing in flight
   assign req_ready = walk_idle;
   assign req_beat  = req_valid && req_ready;

   // output register frees up in the same cycle its beat is taken
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign res_load = walk_fin && out_free;

   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = res_load ? walk_res : rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // views of the waiting result beat for the checks below
   assign out_counted  = rsp_valid_ff && (rsp_data_ff.pages_done != '0);
   assign out_rejected = rsp_valid_ff && (rsp_data_ff.status == tlpt_pkg::ST_UNALIGNED
                                          || rsp_data_ff.status == tlpt_pkg::ST_RANGE);
   assign out_empty    = (rsp_data_ff.pages_done == '0) && (rsp_data_ff.phys_result == '0);

   tlpt_check #(
      .FIRST_LEVEL_SLOTS (FIRST_LEVEL_SLOTS)
   ) u_check (
      .req (req_data),
      .chk (chk)
   );

   tlpt_walk #(
      .FIRST_LEVEL_SLOTS (FIRST_LEVEL_SLOTS),
      .FRAME_BITS        (FRAME_BITS)
   ) u_walk (
      .clock            (clock),
      .reset            (reset),
      .start            (req_beat),
      .req              (req_data),
      .chk              (chk),
      .dummy_page_frame (dummy_ff),
      .out_free         (out_free),
      .idle             (walk_idle),
      .fin              (walk_fin),
      .res              (walk_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dummy_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dummy_ff     <= dummy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // every accepted request leaves the walker busy in the cycle after the beat
   `TLPT_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_beat, !req_ready)

   // a write count only comes with map or unmap, which never carry a frame
   `TLPT_ASSERT_IMPLIES(a_count_no_phys, clock, reset, out_counted, rsp_data_ff.phys_result == '0)

   // rejected requests write nothing and translate nothing
   `TLPT_ASSERT_IMPLIES(a_reject_empty, clock, reset, out_rejected, out_empty)

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the two-level page table engine
`default_nettype none

module testbench;
   import tlpt_pkg::*;

   // geometry of the block under test
   localparam int unsigned SLOT_COUNT  = 16;
   localparam int unsigned TOTAL_PAGES = SLOT_COUNT * SUB_ENTRIES;
   localparam longint unsigned WINDOW_BYTES = longint'(TOTAL_PAGES) << PG_SHIFT;
   localparam logic [31:0] WINDOW_LAST = 32'(WINDOW_BYTES - 1);
   localparam logic [DUMMY_BITS-1:0] FRAME_TOP = '1;

   // run control
   localparam int unsigned CYCLE_LIMIT      = 1_000_000;
   localparam int unsigned HOLD_OFF_CYCLES  = 300;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned DONE_LIMIT       = 32767;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [DUMMY_BITS-1:0] csr_dummy_page_frame;

   // shadow copy of the page table, the used flags and the dummy frame register
   bit                    slot_in_use [SLOT_COUNT];
   logic [DUMMY_BITS-1:0] page_frames [TOTAL_PAGES];
   logic [DUMMY_BITS-1:0] dummy_frame;

   // results predicted for accepted requests, oldest first
   rsp_type pending_results [$];
   rsp_type oldest_result;

   // first pages of recent maps, so lookups and unmaps land on live entries
   int unsigned mapped_pages [$];

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned stall_left;
   bit          steady_flow;
   bit          hold_off_pending;

   two_level_page_table_engine_unit #(
      .FIRST_LEVEL_SLOTS(SLOT_COUNT),
      .FRAME_BITS(DUMMY_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_dummy_page_frame(csr_dummy_page_frame)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none or short, now and then a long one
   function automatic int unsigned draw_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady_flow) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // page count of a random range: mostly short runs, a few crossing a slot
   function automatic int unsigned draw_run_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(0, 16);
      if (roll < 95) return $urandom_range(17, 300);
      return $urandom_range(600, 1500);
   endfunction

   function automatic req_type make_request(input logic [1:0] op, input logic [31:0] io,
                                            input logic [38:0] pa, input logic [31:0] len);
      req_type r;
      r.op           = op;
      r.io_address   = io;
      r.phys_address = pa;
      r.length_bytes = len;
      return r;
   endfunction

   // expected result of one request; updates the shadow table as the block would
   function automatic rsp_type walk_page_table(input req_type r);
      rsp_type               res;
      logic [11:0]           low_bits;
      longint unsigned       range_end;
      logic [DUMMY_BITS-1:0] frame;
      int unsigned           pages;
      int unsigned           first_page;
      int unsigned           pg;
      int unsigned           slot;
      int unsigned           done;
      res  = '0;
      done = 0;
      case (r.op)
         OP_XLATE: begin
            if (r.io_address >= WINDOW_BYTES) begin
               res.status = ST_RANGE;
            end else begin
               slot  = r.io_address >> SLOT_SHIFT;
               frame = slot_in_use[slot] ? page_frames[r.io_address >> PG_SHIFT] : dummy_frame;
               res.phys_result = {frame, 12'h000};
            end
         end
         OP_MAP, OP_UNMAP: begin
            // phys address alignment only matters for map
            low_bits = r.io_address[11:0] | r.length_bytes[11:0]
                     | ((r.op == OP_MAP) ? r.phys_address[11:0] : 12'h000);
            range_end = 64'(r.io_address);
            range_end += 64'(r.length_bytes);
            if (low_bits != 12'h000) begin
               res.status = ST_UNALIGNED;
            end else if (r.io_address >= WINDOW_BYTES || range_end > WINDOW_BYTES) begin
               res.status = ST_RANGE;
            end else begin
               pages      = r.length_bytes >> PG_SHIFT;
               first_page = r.io_address >> PG_SHIFT;
               frame      = r.phys_address[38:12];
               for (int unsigned i = 0; i < pages; i++) begin
                  pg   = first_page + i;
                  slot = pg / SUB_ENTRIES;
                  if (r.op == OP_MAP) begin
                     // first touch sweeps the whole slot with the dummy frame
                     if (!slot_in_use[slot]) begin
                        for (int unsigned k = 0; k < SUB_ENTRIES; k++)
                           page_frames[slot * SUB_ENTRIES + k] = dummy_frame;
                        slot_in_use[slot] = 1'b1;
                     end
                     page_frames[pg] = frame;
                     frame = frame + 1'b1;
                     done++;
                  end else if (slot_in_use[slot]) begin
                     page_frames[pg] = dummy_frame;
                     done++;
                  end else begin
                     res.status = ST_HOLE;
                  end
               end
               res.pages_done = (done > DONE_LIMIT) ? DONE_MAX : 15'(done);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // mix of well-formed map/unmap/translate with some malformed noise;
   // maps stay below slot_limit so upper slots can remain unused
   function automatic req_type random_request(input int unsigned slot_limit);
      req_type     r;
      int unsigned roll;
      int unsigned page;
      int unsigned pages;
      int unsigned span;
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      if (mapped_pages.size() != 0 && $urandom_range(0, 99) < 45)
         page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)] + $urandom_range(0, 40);
      else
         page = $urandom_range(0, TOTAL_PAGES - 1);
      if (page >= TOTAL_PAGES) page = TOTAL_PAGES - 1;
      r = make_request(OP_XLATE, page << PG_SHIFT, {wide[38:12], 12'h000}, 32'h0);
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         page  = page % (slot_limit * SUB_ENTRIES);
         pages = draw_run_length();
         span  = slot_limit * SUB_ENTRIES - page;
         if (pages > span) pages = span;
         r.op           = OP_MAP;
         r.io_address   = page << PG_SHIFT;
         r.length_bytes = pages << PG_SHIFT;
         if (pages != 0) begin
            mapped_pages.push_back(page);
            if (mapped_pages.size() > 32) void'(mapped_pages.pop_front());
         end
      end else if (roll < 55) begin
         pages = draw_run_length();
         span  = TOTAL_PAGES - page;
         if (pages > span) pages = span;
         // phys address is don't-care for unmap, unaligned included
         r.op           = OP_UNMAP;
         r.length_bytes = pages << PG_SHIFT;
         r.phys_address = wide[38:0];
      end else if (roll < 90) begin
         r.io_address[11:0] = 12'($urandom());
      end else begin
         case ($urandom_range(0, 3))
            0: begin
               r.op           = ($urandom_range(0, 1) == 0) ? OP_MAP : OP_UNMAP;
               r.length_bytes = $urandom_range(0, 8) << PG_SHIFT;
               case ($urandom_range(0, 2))
                  0: r.io_address[11:0] = 12'($urandom_range(1, 4095));
                  1: r.length_bytes[11:0] = 12'($urandom_range(1, 4095));
                  default: r.phys_address[11:0] = 12'($urandom_range(1, 4095));
               endcase
            end
            1: begin
               r.op           = 2'($urandom_range(0, 2));
               r.io_address   = $urandom();
               r.length_bytes = $urandom();
            end
            2: begin
               r.op           = OP_NONE;
               r.io_address   = $urandom();
               r.phys_address = wide[38:0];
               r.length_bytes = $urandom();
            end
            default: r.io_address = $urandom() | 32'h0400_0000;
         endcase
      end
      return r;
   endfunction

   // offer one request beat, hold it until taken, then predict its result
   task automatic offer_request(input req_type item);
      int unsigned gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(walk_page_table(item));
   endtask

   task automatic offer_lookup(input logic [31:0] io);
      offer_request(make_request(OP_XLATE, io, 39'h0, 32'h0));
   endtask

   // stop offering, wait for every result, then let the block settle
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only called with the block idle
   task automatic write_dummy_frame(input logic [DUMMY_BITS-1:0] frame);
      @(negedge clock);
      csr_dummy_page_frame <= frame;
      csr_valid            <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      dummy_frame = frame;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // lookups after reset return the reset dummy frame; unused op code; lookup after a dummy frame write
   task automatic test_reset_state();
      offer_lookup(32'h0000_0000);
      offer_request(make_request(OP_NONE, '1, '1, '1));
      drain_results();
      write_dummy_frame(FRAME_TOP);
      offer_lookup(32'h03FF_FFFF);
   endtask

   // each misaligned field, unmap ignoring phys alignment, empty ranges
   task automatic test_alignment();
      offer_request(make_request(OP_MAP, 32'h0000_1001, 39'h0, 32'h1000));
      offer_request(make_request(OP_MAP, 32'h0000_1000, 39'h0_0000_0800, 32'h1000));
      offer_request(make_request(OP_MAP, 32'h0000_1000, 39'h0, 32'h0000_1FFF));
      offer_request(make_request(OP_UNMAP, 32'h0000_2000, 39'h0, 32'h0000_0800));
      offer_request(make_request(OP_UNMAP, 32'h0140_0000, 39'h7F_FFFF_FFFF, 32'h0));
      // empty map must not claim its slot
      offer_request(make_request(OP_MAP, 32'h01C0_0000, 39'h12_3456_7000, 32'h0));
   endtask

   // window edge on start address and on range end
   task automatic test_window_limits();
      offer_lookup(32'h0400_0000);
      offer_lookup(32'hFFFF_FFFF);
      offer_request(make_request(OP_MAP, 32'h03FF_F000, 39'h0, 32'h0000_2000));
      offer_request(make_request(OP_MAP, 32'h0000_0000, 39'h0, 32'hFFFF_F000));
      offer_request(make_request(OP_UNMAP, 32'hFFFF_F000, 39'h0, 32'h0));
   endtask

   // consecutive frames wrap past the top frame number
   task automatic test_frame_wrap();
      offer_request(make_request(OP_MAP, 32'h0040_0000, {27'h7FF_FFFE, 12'h000}, 32'h3000));
      offer_lookup(32'h0040_0ABC);
      offer_lookup(32'h0040_1FFF);
      offer_lookup(32'h0040_2001);
      offer_lookup(32'h0040_3000);
   endtask

   // unmap straddling an unused slot, then a dummy change that must not
   // touch entries already written
   task automatic test_unmap_hole();
      offer_request(make_request(OP_UNMAP, 32'h003F_E000, 39'h0, 32'h0000_4000));
      offer_lookup(32'h0040_0000);
      offer_lookup(32'h0040_2000);
      drain_results();
      write_dummy_frame(27'h000_1234);
      offer_lookup(32'h0040_3000);
      offer_lookup(32'h01C0_0010);
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned slot_limit);
      for (int unsigned n = 0; n < count; n++) begin
         // alternate stretches of free flow with stretches of random idling
         if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         offer_request(random_request(slot_limit));
      end
      steady_flow = 1'b0;
   endtask

   // receiver holds off while lookups keep coming, so the input backs up
   task automatic test_output_stall();
      steady_flow      = 1'b1;
      hold_off_pending = 1'b1;
      for (int unsigned n = 0; n < 16; n++)
         offer_lookup($urandom_range(0, WINDOW_LAST));
      steady_flow = 1'b0;
   endtask

   // map and unmap the whole window in one request each
   task automatic test_full_window();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      drain_results();
      write_dummy_frame(DUMMY_BITS'($urandom()));
      offer_request(make_request(OP_MAP, 32'h0, {wide[38:12], 12'h000}, 32'h0400_0000));
      for (int unsigned n = 0; n < 4; n++)
         offer_lookup($urandom_range(0, WINDOW_LAST));
      offer_request(make_request(OP_UNMAP, 32'h0, 39'h0, 32'h0400_0000));
      offer_lookup(32'h03FF_F000);
      offer_lookup(32'h0000_0000);
   endtask

   // result side: random ready gaps, plus the long hold-off on request
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_left       = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = draw_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare every result beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: status %0d phys %h pages %0d",
                     $time, rsp_data.status, rsp_data.phys_result, rsp_data.pages_done);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.status !== oldest_result.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, oldest_result.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.phys_result !== oldest_result.phys_result) begin
               $display("%0t: phys_result mismatch, expected %h, actual %h",
                        $time, oldest_result.phys_result, rsp_data.phys_result);
               error_count++;
            end
            if (rsp_data.pages_done !== oldest_result.pages_done) begin
               $display("%0t: pages_done mismatch, expected %0d, actual %0d",
                        $time, oldest_result.pages_done, rsp_data.pages_done);
               error_count++;
            end
         end
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_data             = '0;
      csr_valid            = 1'b0;
      csr_dummy_page_frame = '0;
      dummy_frame          = '0;
      error_count          = 0;
      steady_flow          = 1'b0;
      hold_off_pending     = 1'b0;
      foreach (slot_in_use[s]) slot_in_use[s] = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_alignment();
      test_window_limits();
      test_frame_wrap();
      test_unmap_hole();

      // first random pass keeps the top slots unused
      drain_results();
      write_dummy_frame(DUMMY_BITS'($urandom()));
      test_random_traffic(300, 12);

      drain_results();
      write_dummy_frame('0);
      test_random_traffic(330, SLOT_COUNT);

      test_output_stall();
      test_full_window();

      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/tlpt_check.sv
rtl/tlpt_walk.sv
rtl/two_level_page_table_engine_unit.sv
verif/testbench.sv
